// ----- rtl/blw_pkg.sv -----
// Shared types and constants for the bounded list with search.
// Depends on nothing; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package blw_pkg;

   // Number of cells in the row, and derived widths.
   localparam int DEPTH   = 16;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;
   localparam int LEN_W   = 5;

   // Operation codes carried in the request word.
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SEARCH     = 3'd4,
      OP_CLEAR      = 3'd5
   } op_type;

   // Status codes carried in the response word.
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Command from the top level to the row of cells.
   typedef struct packed {
      logic               capture;      // a request word is being accepted
      logic               shift_right;  // push at front
      logic               shift_left;   // remove first
      logic               append;       // push at back
      logic               search;       // compare against the key
      logic [COUNT_W-1:0] count;        // element count before this word
   } cmd_type;

   // Per-cell control derived from the command.
   typedef struct packed {
      logic capture;
      logic shift_right;
      logic shift_left;
      logic load;
      logic search;
      logic in_range;
   } cell_ctrl_type;

endpackage

// ----- rtl/blw_cell.sv -----
// One storage cell of the list: holds a value and a registered match flag.
// Depends on blw_pkg for widths and the control struct.
`timescale 1ns / 1ps

module blw_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  blw_pkg::cell_ctrl_type              ctrl,
   input  logic signed [blw_pkg::VALUE_W-1:0]  key,
   input  logic signed [blw_pkg::VALUE_W-1:0]  left_data,
   input  logic signed [blw_pkg::VALUE_W-1:0]  right_data,
   output logic signed [blw_pkg::VALUE_W-1:0]  data,
   output logic                                hit
);

   logic signed [blw_pkg::VALUE_W-1:0] data_ff;
   logic signed [blw_pkg::VALUE_W-1:0] data_in;
   logic                               hit_ff;
   logic                               hit_in;

   // Next value: take from a neighbour on a shift, the key on an append.
   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_right) begin
         data_in = left_data;
      end else if (ctrl.shift_left) begin
         data_in = right_data;
      end else if (ctrl.load) begin
         data_in = key;
      end
   end

   // A match counts only for a held element during a search.
   always_comb begin
      hit_in = hit_ff;
      if (ctrl.capture) begin
         hit_in = ctrl.search && ctrl.in_range && (data_ff == key);
      end
   end

   // The stored value needs no reset; the match flag does.
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign data = data_ff;
   assign hit  = hit_ff;

endmodule

// ----- rtl/blw_chain.sv -----
// The row of cells: links neighbours and decodes the command for each cell.
// Depends on blw_pkg and blw_cell.
`timescale 1ns / 1ps

module blw_chain (
   input  logic                                clock,
   input  logic                                reset,
   input  blw_pkg::cmd_type                    cmd,
   input  logic signed [blw_pkg::VALUE_W-1:0]  key,
   output logic [blw_pkg::DEPTH-1:0]           hits
);

   logic signed [blw_pkg::VALUE_W-1:0] cell_data [blw_pkg::DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < blw_pkg::DEPTH; gi++) begin : g_cell
         blw_pkg::cell_ctrl_type             ctrl;
         logic signed [blw_pkg::VALUE_W-1:0] left_data;
         logic signed [blw_pkg::VALUE_W-1:0] right_data;

         // The front cell takes the key on a push at front; the last cell
         // keeps its own value on a removal from the front.
         if (gi == 0) begin : g_front
            assign left_data = key;
         end else begin : g_inner_l
            assign left_data = cell_data[gi-1];
         end
         if (gi == blw_pkg::DEPTH - 1) begin : g_back
            assign right_data = cell_data[gi];
         end else begin : g_inner_r
            assign right_data = cell_data[gi+1];
         end

         // Decode the shared command for this position.
         always_comb begin
            ctrl.capture     = cmd.capture;
            ctrl.shift_right = cmd.shift_right;
            ctrl.shift_left  = cmd.shift_left;
            ctrl.load        = cmd.append && (cmd.count == blw_pkg::COUNT_W'(gi));
            ctrl.search      = cmd.search;
            ctrl.in_range    = blw_pkg::COUNT_W'(gi) < cmd.count;
         end

         blw_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .key        (key),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[gi]),
            .hit        (hits[gi])
         );
      end
   endgenerate

endmodule

// ----- rtl/bounded_list_with_search.sv -----
// Top level of the bounded list with search: request decode, count, output word.
// Depends on blw_pkg and blw_chain.
`timescale 1ns / 1ps

// A double-ended list of up to 16 signed 32-bit values held in a row of
// cells, front in cell zero. Each request word carries an operation and a
// value; each yields exactly one response word with status, found flag and
// the element count after the operation. One request word is accepted per
// cycle while the response side keeps up; its response word is registered
// first in the pending stage, as the cells shift or load and register their
// match flags, and then in the output register, where the flags are ORed,
// once the output register frees. A stalled output holds two words, one
// pending and one in the output register, before the request side is held
// off. A push into a full list reports full and stores nothing; a removal
// from an empty list reports empty.

module bounded_list_with_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // opcode[2:0], value[34:3], zeros[39:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // status[1:0], found[2], length[7:3]
);

   localparam int CW = blw_pkg::COUNT_W;

   blw_pkg::op_type                    op;
   logic signed [blw_pkg::VALUE_W-1:0] key;
   logic                               accept;
   logic                               out_free;
   logic                               full;
   logic                               empty;
   logic [blw_pkg::DEPTH-1:0]          hits;
   blw_pkg::cmd_type                   cmd;
   blw_pkg::status_type                status_in;

   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic                         pend_valid_ff;
   blw_pkg::status_type          pend_status_ff;
   logic [blw_pkg::LEN_W-1:0]    pend_len_ff;
   logic                         rsp_valid_ff;
   blw_pkg::status_type          rsp_status_ff;
   logic                         rsp_found_ff;
   logic [blw_pkg::LEN_W-1:0]    rsp_len_ff;

   // Unpack the request word.
   assign op  = blw_pkg::op_type'(req_tdata[2:0]);
   assign key = signed'(req_tdata[34:3]);

   // Handshake: the pending stage moves on whenever the output register frees.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !pend_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   assign full  = count_ff == CW'(blw_pkg::DEPTH);
   assign empty = count_ff == '0;

   // Decode the operation into a cell command, new count and status.
   always_comb begin
      cmd         = '0;
      cmd.capture = accept;
      cmd.count   = count_ff;
      count_in    = count_ff;
      status_in   = blw_pkg::ST_OK;
      if (accept) begin
         case (op)
            blw_pkg::OP_PUSH_FRONT: begin
               if (full) begin
                  status_in = blw_pkg::ST_FULL;
               end else begin
                  cmd.shift_right = 1'b1;
                  count_in        = count_ff + 1'b1;
               end
            end
            blw_pkg::OP_PUSH_BACK: begin
               if (full) begin
                  status_in = blw_pkg::ST_FULL;
               end else begin
                  cmd.append = 1'b1;
                  count_in   = count_ff + 1'b1;
               end
            end
            blw_pkg::OP_POP_FRONT: begin
               if (empty) begin
                  status_in = blw_pkg::ST_EMPTY;
               end else begin
                  cmd.shift_left = 1'b1;
                  count_in       = count_ff - 1'b1;
               end
            end
            blw_pkg::OP_POP_BACK: begin
               if (empty) begin
                  status_in = blw_pkg::ST_EMPTY;
               end else begin
                  count_in = count_ff - 1'b1;
               end
            end
            blw_pkg::OP_SEARCH: begin
               cmd.search = 1'b1;
            end
            blw_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   blw_chain u_chain (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .key   (key),
      .hits  (hits)
   );

   // Element count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Pending stage: holds status and length while the cells hold the matches.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (accept) begin
         pend_valid_ff <= 1'b1;
      end else if (out_free) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_status_ff <= status_in;
         pend_len_ff    <= blw_pkg::LEN_W'(count_in);
      end
   end

   // Output register: the match flags are combined here.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && pend_valid_ff) begin
         rsp_status_ff <= pend_status_ff;
         rsp_found_ff  <= |hits;
         rsp_len_ff    <= pend_len_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_found_ff, rsp_status_ff};

   // A word waiting in the pending stage is not dropped while the output stalls.
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && !out_free |=> pend_valid_ff)
      else $error("pending word lost while output stalled");

   // The count never passes the number of cells.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(blw_pkg::DEPTH))
      else $error("element count exceeds depth");

   // A found flag only comes with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_status_ff == blw_pkg::ST_OK)
      else $error("found flag with a failing status");

   // A push into a full list leaves the count unchanged.
   assert property (@(posedge clock) disable iff (reset)
      accept && full && (op == blw_pkg::OP_PUSH_FRONT || op == blw_pkg::OP_PUSH_BACK)
      |=> $stable(count_ff))
      else $error("push into a full list changed the count");

endmodule

// ----- sim/bounded_list_with_search_checker.sv -----
// Checker for the bounded list with search: predicts every response word and compares it.
// Depends on blw_pkg; instantiated beside the block by bounded_list_with_search_tb.
`timescale 1ns / 1ps

module bounded_list_with_search_checker
   import blw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // opcode[2:0], value[34:3], zeros[39:35]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // status[1:0], found[2], length[7:3]
   output int          fail_count,
   output int          pending_count
);

   // One predicted response word.
   typedef struct packed {
      status_type         status;
      logic               found;
      logic [LEN_W-1:0]   length;
   } outcome_type;

   // Shadow copy of the list, front first, and the responses still to arrive.
   logic [VALUE_W-1:0] shadow_list[$];
   outcome_type        awaited_outcomes[$];

   // Applies one operation to the shadow list and returns the response it should give.
   function automatic outcome_type list_op_outcome(input logic [OP_W-1:0]    opcode,
                                                   input logic [VALUE_W-1:0] value);
      outcome_type outcome;
      outcome.status = ST_OK;
      outcome.found  = 1'b0;
      case (opcode)
         OP_PUSH_FRONT: begin
            if (shadow_list.size() >= DEPTH) outcome.status = ST_FULL;
            else shadow_list.push_front(value);
         end
         OP_PUSH_BACK: begin
            if (shadow_list.size() >= DEPTH) outcome.status = ST_FULL;
            else shadow_list.push_back(value);
         end
         OP_POP_FRONT: begin
            if (shadow_list.size() == 0) outcome.status = ST_EMPTY;
            else void'(shadow_list.pop_front());
         end
         OP_POP_BACK: begin
            if (shadow_list.size() == 0) outcome.status = ST_EMPTY;
            else void'(shadow_list.pop_back());
         end
         OP_SEARCH: begin
            foreach (shadow_list[i])
               if (shadow_list[i] == value) outcome.found = 1'b1;
         end
         OP_CLEAR: begin
            shadow_list.delete();
         end
         default: ;
      endcase
      outcome.length = LEN_W'(shadow_list.size());
      return outcome;
   endfunction

   // Predict on each accepted request word, compare each accepted response word.
   always @(posedge clock) begin
      outcome_type seen;
      outcome_type wanted;
      if (reset) begin
         shadow_list.delete();
         awaited_outcomes.delete();
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready)
            awaited_outcomes.push_back(list_op_outcome(req_tdata[OP_W-1:0],
                                                       req_tdata[OP_W +: VALUE_W]));
         if (rsp_tvalid && rsp_tready) begin
            seen.status = status_type'(rsp_tdata[1:0]);
            seen.found  = rsp_tdata[2];
            seen.length = rsp_tdata[7:3];
            if (awaited_outcomes.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response word with none awaited: status %0d found %0d length %0d",
                           $realtime, seen.status, seen.found, seen.length);
               fail_count = fail_count + 1;
            end else begin
               wanted = awaited_outcomes.pop_front();
               if (seen.status !== wanted.status || seen.found !== wanted.found ||
                   seen.length !== wanted.length) begin
                  if (fail_count < 10)
                     $display({"%0t: response mismatch: expected status %0d found %0d length %0d,",
                               " got status %0d found %0d length %0d"},
                              $realtime, wanted.status, wanted.found, wanted.length,
                              seen.status, seen.found, seen.length);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      pending_count <= awaited_outcomes.size();
   end

endmodule

// ----- sim/bounded_list_with_search_tb.sv -----
// Testbench top for the bounded list with search: clock, reset, request and response traffic.
// Depends on blw_pkg, bounded_list_with_search and bounded_list_with_search_checker.
`timescale 1ns / 1ps

module bounded_list_with_search_tb;
   import blw_pkg::*;

   // Opcodes that the block treats as no operation.
   localparam logic [OP_W-1:0] OP_SPARE_SIX   = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_SEVEN = 3'd7;

   localparam int RANDOM_WORDS = 1950;
   localparam int LONG_HOLD    = 200;
   localparam int DRAIN_LIMIT  = 2000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   int          fail_count;
   int          pending_count;

   bit                 sender_quiet   = 1'b0;
   bit                 receiver_quiet = 1'b0;
   logic [VALUE_W-1:0] value_pool[8];

   always #5 clock = ~clock;

   bounded_list_with_search u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bounded_list_with_search_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Offers one request word after a random gap (none while the sender is quiet) and waits until it is taken.
   task automatic offer_word(input logic [OP_W-1:0] opcode, input logic [VALUE_W-1:0] value);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {5'b0, value, opcode};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Waits, with a bound, until no response word is awaited any more.
   task automatic wait_for_drain();
      int guard;
      guard = 0;
      @(posedge clock);
      while (pending_count != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // Values drawn half the time from a small pool so that searches often hit.
   function automatic logic [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 1) == 0) return $urandom;
      return value_pool[$urandom_range(0, 7)];
   endfunction

   // Request side: a directed opening, then random phases that fill and drain the list.
   initial begin
      int mode_left;
      int roll;
      bit push_heavy;
      logic [OP_W-1:0] opcode;
      mode_left  = 0;
      push_heavy = 1'b0;
      foreach (value_pool[k]) value_pool[k] = $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty list, spare opcodes and the extremes of the value.
      offer_word(OP_POP_FRONT, $urandom);
      offer_word(OP_POP_BACK, $urandom);
      offer_word(OP_SEARCH, 32'h0000_0000);
      offer_word(OP_SPARE_SIX, $urandom);
      offer_word(OP_SPARE_SEVEN, $urandom);
      offer_word(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      offer_word(OP_PUSH_BACK, 32'h8000_0000);
      offer_word(OP_SEARCH, 32'h8000_0000);
      offer_word(OP_SEARCH, 32'h7FFF_FFFE);
      offer_word(OP_POP_BACK, $urandom);
      // Removal of the only element.
      offer_word(OP_POP_FRONT, $urandom);

      // Fill from both ends, search, push into a full list, then clear and pop the empty list.
      for (int k = 0; k < DEPTH; k++)
         offer_word(k[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                    (k < DEPTH / 2) ? 32'hFFFF_FFFF : 32'h0000_0000);
      offer_word(OP_SEARCH, 32'hFFFF_FFFF);
      offer_word(OP_PUSH_FRONT, 32'h1234_5678);
      offer_word(OP_PUSH_BACK, 32'h8765_4321);
      offer_word(OP_CLEAR, $urandom);
      offer_word(OP_POP_FRONT, $urandom);

      // Random phases alternate between growing and shrinking the list.
      for (int item = 0; item < RANDOM_WORDS; item++) begin
         if (mode_left == 0) begin
            push_heavy   = ~push_heavy;
            mode_left    = $urandom_range(30, 80);
            sender_quiet = ($urandom_range(0, 3) == 0);
         end
         mode_left--;
         if ($urandom_range(0, 15) == 0) value_pool[$urandom_range(0, 7)] = $urandom;
         roll = $urandom_range(0, 99);
         if (push_heavy) begin
            if (roll < 25)      opcode = OP_PUSH_FRONT;
            else if (roll < 50) opcode = OP_PUSH_BACK;
            else if (roll < 58) opcode = OP_POP_FRONT;
            else if (roll < 66) opcode = OP_POP_BACK;
            else if (roll < 94) opcode = OP_SEARCH;
            else if (roll < 95) opcode = OP_CLEAR;
            else if (roll < 97) opcode = OP_SPARE_SIX;
            else                opcode = OP_SPARE_SEVEN;
         end else begin
            if (roll < 8)       opcode = OP_PUSH_FRONT;
            else if (roll < 16) opcode = OP_PUSH_BACK;
            else if (roll < 45) opcode = OP_POP_FRONT;
            else if (roll < 74) opcode = OP_POP_BACK;
            else if (roll < 94) opcode = OP_SEARCH;
            else if (roll < 95) opcode = OP_CLEAR;
            else if (roll < 97) opcode = OP_SPARE_SIX;
            else                opcode = OP_SPARE_SEVEN;
         end
         // Once, the sender pauses until every response word has come back.
         if (item == 1000) begin
            req_tvalid <= 1'b0;
            wait_for_drain();
         end
         offer_word(opcode, pick_value());
      end

      req_tvalid <= 1'b0;
      wait_for_drain();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("bounded_list_with_search_tb passed");
      end else begin
         $display("bounded_list_with_search_tb failed");
      end
      $finish;
   end

   // Response side: random stalls, quiet stretches and two long hold-offs.
   initial begin
      int delivered;
      int stall;
      delivered = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (delivered == 300 || delivered == 1200) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            stall = receiver_quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         delivered++;
         if (delivered % 60 == 0) receiver_quiet = ($urandom_range(0, 2) == 0);
      end
   end

   // Overall time limit.
   initial begin
      #4_000_000;
      $display("bounded_list_with_search_tb failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/blw_pkg.sv
rtl/blw_cell.sv
rtl/blw_chain.sv
rtl/bounded_list_with_search.sv
sim/bounded_list_with_search_checker.sv
sim/bounded_list_with_search_tb.sv
